FILE: rtl/core/svpwm_pkg.sv
package svpwm_pkg;

  // Field widths of the ports and configuration registers
  localparam int HP_W       = 16;
  localparam int MI_W       = 16;
  localparam int STEP_W     = 11;
  localparam int LIMIT_W    = 16;
  localparam int CMP_W      = 16;
  localparam int SEC_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Sine values in Q0.30; within one sector they stay below one
  localparam int SIN_W = 30;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  localparam logic [HP_W-1:0]    HALF_PERIOD_RST = 16'd4625;
  localparam logic [MI_W-1:0]    MOD_INDEX_RST   = 16'd64225;
  localparam logic [STEP_W-1:0]  PHASE_STEP_RST  = 11'd6;
  localparam logic [LIMIT_W-1:0] COUNT_LIMIT_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_PERIOD = 2'd0,
    REG_MOD_INDEX   = 2'd1,
    REG_PHASE_STEP  = 2'd2,
    REG_COUNT_LIMIT = 2'd3
  } reg_idx_t;

  // Sector code as held internally; the port shows it plus one
  typedef enum logic [SEC_W-1:0] {
    SEC_I   = 3'd0,
    SEC_II  = 3'd1,
    SEC_III = 3'd2,
    SEC_IV  = 3'd3,
    SEC_V   = 3'd4,
    SEC_VI  = 3'd5
  } sector_t;

  typedef enum logic [1:0] {
    MUL_ROM   = 2'd0,
    MUL_SUM_A = 2'd1,
    MUL_SUM_B = 2'd2,
    MUL_SUM_C = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic [HP_W-1:0]    half_period;
    logic [MI_W-1:0]    modulation_index;
    logic [STEP_W-1:0]  phase_step;
    logic [LIMIT_W-1:0] count_limit;
  } cfg_t;

  typedef struct packed {
    logic     load_sect;
    logic     rd_rom;
    logic     rom_sel_m;
    mul_sel_t mul_sel;
    logic     cap_dm;
    logic     cap_dn;
    logic     form_sums;
    logic     cap_cmp_a;
    logic     cap_cmp_b;
    logic     cap_cmp_c;
    logic     mod_step;
    logic     commit;
  } dp_cmd_t;

  // Restoring steps needed to bring a value up to max_val below ps
  function automatic int mod_steps(int ps, int max_val);
    int n;
    n = 1;
    for (int i = 1; i < 16; i++) begin
      if ((ps << n) <= max_val) n = n + 1;
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/svpwm_in_if.sv
interface svpwm_in_if import svpwm_pkg::*; ();
  logic valid;
  logic ready;
  logic reload;

  modport source (output valid, output reload, input ready);
  modport sink   (input valid, input reload, output ready);
endinterface

FILE: rtl/core/svpwm_out_if.sv
interface svpwm_out_if import svpwm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMP_W-1:0] compare_a;
  logic [CMP_W-1:0] compare_b;
  logic [CMP_W-1:0] compare_c;
  logic [SEC_W-1:0] sector_number;

  modport source (output valid, output compare_a, output compare_b, output compare_c,
                  output sector_number, input ready);
  modport sink   (input valid, input compare_a, input compare_b, input compare_c,
                  input sector_number, output ready);
endinterface

FILE: rtl/core/svpwm_cfg_if.sv
interface svpwm_cfg_if import svpwm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: rtl/core/svpwm_compare_generator.sv
// Space vector PWM compare generator. Each input word with reload set marks one
// carrier reload tick and yields one output word: the three phase compare values
// (half_period minus the on-time of that phase) and the sector, 1 to 6, used for
// the tick. A word with reload clear is taken and dropped with no output word.
// Phase advances by phase_step per tick modulo PHASE_STEPS; once the tick counter
// passes count_limit, counter and phase restart at zero. A tick runs through the
// sector split, two sine ROM reads, the duty and sum steps, three compare products
// and MOD_STEPS restoring subtract steps for the phase wrap (2 for the default
// PHASE_STEPS of 1200); no new word is taken until its output word is written.
// The datapath has a single shared 16x30 multiplier, used five times per tick,
// and a registered sine ROM, read twice. The output register holds a finished
// word while the next tick is taken and worked on. Configuration writes are
// always ready and must only be issued while the block is idle.
module svpwm_compare_generator import svpwm_pkg::*; #(
  parameter int PHASE_STEPS    = 1200,
  parameter int DUTY_FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  svpwm_in_if.sink    in_ch,
  svpwm_out_if.source out_ch,
  svpwm_cfg_if.sink   cfg_ch
);

  cfg_t    cfg_r, cfg_nxt;
  dp_cmd_t cmd;
  logic    mod_last;

  // Register file: take a word on every cycle, ignore nothing
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.reg_index))
        REG_HALF_PERIOD: cfg_nxt.half_period      = cfg_ch.wdata[HP_W-1:0];
        REG_MOD_INDEX:   cfg_nxt.modulation_index = cfg_ch.wdata[MI_W-1:0];
        REG_PHASE_STEP:  cfg_nxt.phase_step       = cfg_ch.wdata[STEP_W-1:0];
        REG_COUNT_LIMIT: cfg_nxt.count_limit      = cfg_ch.wdata[LIMIT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period      <= HALF_PERIOD_RST;
      cfg_r.modulation_index <= MOD_INDEX_RST;
      cfg_r.phase_step       <= PHASE_STEP_RST;
      cfg_r.count_limit      <= COUNT_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Sequencer: steps the datapath through one tick, owns both handshakes
  svpwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_reload (in_ch.reload),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .mod_last  (mod_last),
    .cmd       (cmd)
  );

  // Sector split, sine ROM, shared multiplier, duty sums, phase wrap
  svpwm_dp #(
    .PHASE_STEPS    (PHASE_STEPS),
    .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd           (cmd),
    .mod_last      (mod_last),
    .compare_a     (out_ch.compare_a),
    .compare_b     (out_ch.compare_b),
    .compare_c     (out_ch.compare_c),
    .sector_number (out_ch.sector_number)
  );

endmodule

FILE: rtl/core/svpwm_ctrl.sv
module svpwm_ctrl import svpwm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_reload,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  input  logic    mod_last,
  output dp_cmd_t cmd
);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_SECT  = 13'b0000000000010,
    ST_ROMM  = 13'b0000000000100,
    ST_ROMN  = 13'b0000000001000,
    ST_MULN  = 13'b0000000010000,
    ST_DUTY  = 13'b0000000100000,
    ST_SUMS  = 13'b0000001000000,
    ST_MULA  = 13'b0000010000000,
    ST_MULB  = 13'b0000100000000,
    ST_MULC  = 13'b0001000000000,
    ST_LASTC = 13'b0010000000000,
    ST_MODS  = 13'b0100000000000,
    ST_WRITE = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid && in_reload) state_nxt = ST_SECT;
      ST_SECT:  state_nxt = ST_ROMM;
      ST_ROMM:  state_nxt = ST_ROMN;
      ST_ROMN:  state_nxt = ST_MULN;
      ST_MULN:  state_nxt = ST_DUTY;
      ST_DUTY:  state_nxt = ST_SUMS;
      ST_SUMS:  state_nxt = ST_MULA;
      ST_MULA:  state_nxt = ST_MULB;
      ST_MULB:  state_nxt = ST_MULC;
      ST_MULC:  state_nxt = ST_LASTC;
      ST_LASTC: state_nxt = ST_MODS;
      ST_MODS:  if (mod_last) state_nxt = ST_WRITE;
      ST_WRITE: if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (state_r == ST_WRITE && slot_free) out_valid_nxt = 1'b1;
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MUL_ROM;
    unique case (state_r)
      ST_SECT:  cmd.load_sect = 1'b1;
      ST_ROMM:  begin
        cmd.rd_rom    = 1'b1;
        cmd.rom_sel_m = 1'b1;
      end
      ST_ROMN:  cmd.rd_rom = 1'b1;
      ST_MULN:  cmd.cap_dm = 1'b1;
      ST_DUTY:  cmd.cap_dn = 1'b1;
      ST_SUMS:  cmd.form_sums = 1'b1;
      ST_MULA:  cmd.mul_sel = MUL_SUM_A;
      ST_MULB:  begin
        cmd.mul_sel   = MUL_SUM_B;
        cmd.cap_cmp_a = 1'b1;
      end
      ST_MULC:  begin
        cmd.mul_sel   = MUL_SUM_C;
        cmd.cap_cmp_b = 1'b1;
      end
      ST_LASTC: cmd.cap_cmp_c = 1'b1;
      ST_MODS:  cmd.mod_step = 1'b1;
      ST_WRITE: cmd.commit = slot_free;
      default:  cmd.load_sect = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/svpwm_dp.sv
module svpwm_dp import svpwm_pkg::*; #(
  parameter int PHASE_STEPS    = 1200,
  parameter int DUTY_FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  dp_cmd_t          cmd,
  output logic             mod_last,
  output logic [CMP_W-1:0] compare_a,
  output logic [CMP_W-1:0] compare_b,
  output logic [CMP_W-1:0] compare_c,
  output logic [SEC_W-1:0] sector_number
);

  localparam int ACC_W     = $clog2(PHASE_STEPS);
  localparam int RA_W      = $clog2(PHASE_STEPS + 1);
  localparam int Q_W       = $clog2(6 * PHASE_STEPS);
  localparam int STEP_MAX  = (1 << STEP_W) - 1;
  localparam int MV_W      = $clog2(PHASE_STEPS + STEP_MAX);
  localparam int MOD_STEPS = mod_steps(PHASE_STEPS, PHASE_STEPS - 1 + STEP_MAX);
  localparam int SH_W      = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam int DV_W      = MV_W + MOD_STEPS;
  localparam int D_W       = DUTY_FRAC_BITS;
  localparam int PROD_W    = MI_W + SIN_W;
  localparam int DUTY_SH   = 47 - DUTY_FRAC_BITS;
  localparam logic [D_W-1:0] HALF = D_W'(1) << (D_W - 1);

  typedef logic [PHASE_STEPS:0][SIN_W-1:0] rom_t;

  // Sine over one sector, evaluated once at elaboration with truncating steps
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    rom = '0;
    for (int p = 0; p <= PHASE_STEPS; p++) begin
      x  = (64'(p) * PI_Q30) / 64'(3 * PHASE_STEPS);
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      rom[p] = SIN_W'((x * t) >> 30);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [ACC_W-1:0]   phase_accum_r;
  logic [LIMIT_W-1:0] tick_count_r;
  logic [SEC_W-1:0]   sec_r;
  logic [ACC_W-1:0]   r_r;
  logic [SIN_W-1:0]   rom_q_r;
  logic [PROD_W-1:0]  prod_r;
  logic [D_W-1:0]     dm_r, dn_r;
  logic [D_W-1:0]     sa_r, sb_r, sc_r;
  logic [CMP_W-1:0]   cmp_a_r, cmp_b_r, cmp_c_r;
  logic [MV_W-1:0]    mod_val_r;
  logic [SH_W-1:0]    shift_r;
  logic [CMP_W-1:0]   out_a_r, out_b_r, out_c_r;
  logic [SEC_W-1:0]   out_sec_r;

  logic [Q_W-1:0]     q_c, base_c;
  logic [SEC_W-1:0]   sec_c;
  logic [RA_W-1:0]    rom_addr;
  logic [MI_W-1:0]    mul_a;
  logic [SIN_W-1:0]   mul_b;
  logic [D_W-1:0]     duty_c;
  logic [CMP_W-1:0]   cmp_c;
  logic [D_W-1:0]     dsum, d0, s0, s1, s2;
  logic [DV_W-1:0]    divisor;
  logic               sub_ok;
  logic [LIMIT_W:0]   tick_inc;
  logic               wrap;

  // Sector from phase times six against the five sector boundaries
  always_comb begin
    q_c    = Q_W'(phase_accum_r) * Q_W'(6);
    sec_c  = '0;
    base_c = '0;
    for (int k = 1; k < 6; k++) begin
      if (q_c >= Q_W'(k * PHASE_STEPS)) begin
        sec_c  = SEC_W'(k);
        base_c = Q_W'(k * PHASE_STEPS);
      end
    end
  end

  assign rom_addr = cmd.rom_sel_m ? (RA_W'(PHASE_STEPS) - RA_W'(r_r)) : RA_W'(r_r);

  always_comb begin
    mul_a = (cmd.mul_sel == MUL_ROM) ? cfg.modulation_index : cfg.half_period;
    unique case (cmd.mul_sel)
      MUL_ROM:   mul_b = rom_q_r;
      MUL_SUM_A: mul_b = SIN_W'(sa_r);
      MUL_SUM_B: mul_b = SIN_W'(sb_r);
      MUL_SUM_C: mul_b = SIN_W'(sc_r);
      default:   mul_b = rom_q_r;
    endcase
  end

  assign duty_c = D_W'(prod_r[DUTY_SH +: (D_W - 1)]);
  assign cmp_c  = cfg.half_period - prod_r[D_W +: CMP_W];

  // Zero vector time takes what the two active vectors leave of one half
  assign dsum = dm_r + dn_r;
  assign d0   = (dsum < HALF) ? ((HALF - dsum) >> 1) : '0;
  assign s0   = d0;
  assign s2   = d0 + dsum;

  always_comb begin
    s1 = d0 + dn_r;
    if (sec_r == SEC_I || sec_r == SEC_III || sec_r == SEC_V) s1 = d0 + dm_r;
  end

  assign divisor  = DV_W'(PHASE_STEPS) << shift_r;
  assign sub_ok   = DV_W'(mod_val_r) >= divisor;
  assign mod_last = (shift_r == '0);

  assign tick_inc = {1'b0, tick_count_r} + (LIMIT_W + 1)'(1);
  assign wrap     = tick_inc > {1'b0, cfg.count_limit};

  always_ff @(posedge clk) begin
    if (cmd.load_sect) begin
      sec_r     <= sec_c;
      r_r       <= ACC_W'(q_c - base_c);
      mod_val_r <= MV_W'(phase_accum_r) + MV_W'(cfg.phase_step);
      shift_r   <= SH_W'(MOD_STEPS - 1);
    end
    if (cmd.rd_rom) rom_q_r <= SINE_ROM[rom_addr];
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (cmd.cap_dm) dm_r <= duty_c;
    if (cmd.cap_dn) dn_r <= duty_c;
    if (cmd.form_sums) begin
      unique case (sec_r)
        SEC_I:   begin sa_r <= s0; sb_r <= s1; sc_r <= s2; end
        SEC_II:  begin sa_r <= s1; sb_r <= s0; sc_r <= s2; end
        SEC_III: begin sa_r <= s2; sb_r <= s0; sc_r <= s1; end
        SEC_IV:  begin sa_r <= s2; sb_r <= s1; sc_r <= s0; end
        SEC_V:   begin sa_r <= s1; sb_r <= s2; sc_r <= s0; end
        default: begin sa_r <= s0; sb_r <= s2; sc_r <= s1; end
      endcase
    end
    if (cmd.cap_cmp_a) cmp_a_r <= cmp_c;
    if (cmd.cap_cmp_b) cmp_b_r <= cmp_c;
    if (cmd.cap_cmp_c) cmp_c_r <= cmp_c;
    if (cmd.mod_step) begin
      if (sub_ok) mod_val_r <= mod_val_r - MV_W'(divisor);
      if (!mod_last) shift_r <= shift_r - SH_W'(1);
    end
    if (cmd.commit) begin
      out_a_r   <= cmp_a_r;
      out_b_r   <= cmp_b_r;
      out_c_r   <= cmp_c_r;
      out_sec_r <= sec_r + SEC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_accum_r <= '0;
      tick_count_r  <= '0;
    end else if (cmd.commit) begin
      if (wrap) begin
        phase_accum_r <= '0;
        tick_count_r  <= '0;
      end else begin
        phase_accum_r <= ACC_W'(mod_val_r);
        tick_count_r  <= tick_inc[LIMIT_W-1:0];
      end
    end
  end

  assign compare_a     = out_a_r;
  assign compare_b     = out_b_r;
  assign compare_c     = out_c_r;
  assign sector_number = out_sec_r;

endmodule

FILE: sim/svpwm_compare_check.sv
`timescale 1ns / 100ps

// Watches the three channels, keeps its own copy of the registers and the
// tick state, and compares each output word with the oldest predicted one.
module svpwm_compare_check import svpwm_pkg::*; #(
  parameter int PHASE_STEPS    = 1200,
  parameter int DUTY_FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  svpwm_in_if   in_ch,
  svpwm_out_if  out_ch,
  svpwm_cfg_if  cfg_ch,
  output int    mismatches,
  output int    outstanding
);

  localparam logic [63:0] STEPS64 = 64'(PHASE_STEPS);

  typedef struct packed {
    logic [CMP_W-1:0] cmp_a;
    logic [CMP_W-1:0] cmp_b;
    logic [CMP_W-1:0] cmp_c;
    logic [SEC_W-1:0] sector;
  } compare_word_t;

  compare_word_t expected_words[$];
  cfg_t          regs;
  int unsigned   tick_count;
  logic [63:0]   phase;

  // Sine of pos/PHASE_STEPS of a sector (60 degrees), Q0.30, truncated series
  function automatic logic [63:0] sector_sine(input logic [63:0] pos);
    logic [63:0] x, x2, t;
    x  = (pos * PI_Q30) / (64'd3 * STEPS64);
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    return (x * t) >> 30;
  endfunction

  function automatic logic [63:0] half_duty(input logic [63:0] s);
    logic [63:0] m;
    m = 64'(regs.modulation_index);
    return (m * s) >> (47 - DUTY_FRAC_BITS);
  endfunction

  function automatic logic [CMP_W-1:0] compare_of(input logic [63:0] sum);
    logic [63:0] hp, on_time, diff;
    hp      = 64'(regs.half_period);
    on_time = (hp * sum) >> DUTY_FRAC_BITS;
    if (on_time > hp) on_time = hp;
    diff = hp - on_time;
    return diff[CMP_W-1:0];
  endfunction

  function automatic compare_word_t predict_tick(input logic [63:0] ph);
    logic [63:0]   q, r, dm, dn, d0, s1, s2, sec_raw;
    longint        spare;
    sector_t       sec;
    compare_word_t w;
    q       = ph * 64'd6;
    sec_raw = q / STEPS64;
    sec     = (sec_raw > 64'd5) ? SEC_VI : sector_t'(sec_raw[SEC_W-1:0]);
    r       = q - 64'(sec) * STEPS64;
    dm      = half_duty(sector_sine(STEPS64 - r));
    dn      = half_duty(sector_sine(r));
    spare   = longint'(64'd1 << (DUTY_FRAC_BITS - 1)) - longint'(dm) - longint'(dn);
    d0      = (spare > 0) ? 64'(spare >>> 1) : 64'd0;
    s2      = d0 + dm + dn;
    case (sec)
      SEC_I, SEC_III, SEC_V: s1 = d0 + dm;
      default:               s1 = d0 + dn;
    endcase
    case (sec)
      SEC_I: begin
        w.cmp_a = compare_of(d0); w.cmp_b = compare_of(s1); w.cmp_c = compare_of(s2);
      end
      SEC_II: begin
        w.cmp_a = compare_of(s1); w.cmp_b = compare_of(d0); w.cmp_c = compare_of(s2);
      end
      SEC_III: begin
        w.cmp_a = compare_of(s2); w.cmp_b = compare_of(d0); w.cmp_c = compare_of(s1);
      end
      SEC_IV: begin
        w.cmp_a = compare_of(s2); w.cmp_b = compare_of(s1); w.cmp_c = compare_of(d0);
      end
      SEC_V: begin
        w.cmp_a = compare_of(s1); w.cmp_b = compare_of(s2); w.cmp_c = compare_of(d0);
      end
      default: begin
        w.cmp_a = compare_of(d0); w.cmp_b = compare_of(s2); w.cmp_c = compare_of(s1);
      end
    endcase
    w.sector = SEC_W'(sec) + 3'd1;
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : monitor
    compare_word_t want;
    if (!rst_n) begin
      regs.half_period      = HALF_PERIOD_RST;
      regs.modulation_index = MOD_INDEX_RST;
      regs.phase_step       = PHASE_STEP_RST;
      regs.count_limit      = COUNT_LIMIT_RST;
      tick_count            = 0;
      phase                 = 64'd0;
      expected_words.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("output word with nothing expected");
        end else begin
          want = expected_words.pop_front();
          check_field("compare_a", int'(out_ch.compare_a), int'(want.cmp_a));
          check_field("compare_b", int'(out_ch.compare_b), int'(want.cmp_b));
          check_field("compare_c", int'(out_ch.compare_c), int'(want.cmp_c));
          check_field("sector_number", int'(out_ch.sector_number), int'(want.sector));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_HALF_PERIOD: regs.half_period      = cfg_ch.wdata;
          REG_MOD_INDEX:   regs.modulation_index = cfg_ch.wdata;
          REG_PHASE_STEP:  regs.phase_step       = cfg_ch.wdata[STEP_W-1:0];
          REG_COUNT_LIMIT: regs.count_limit      = cfg_ch.wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready && in_ch.reload) begin
        expected_words.push_back(predict_tick(phase));
        tick_count++;
        if (tick_count > 32'(regs.count_limit)) begin
          tick_count = 0;
          phase      = 64'd0;
        end else begin
          phase = (phase + 64'(regs.phase_step)) % STEPS64;
        end
      end
    end
    outstanding = expected_words.size();
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the SVPWM compare generator. The checker beside the
// block does all prediction and comparison; this module only drives words,
// register writes and output back-pressure, and decides pass or fail.
module testbench;
  import svpwm_pkg::*;

  localparam int WATCHDOG_LIMIT    = 1000;
  // Margin when settling, after every predicted word has come out
  localparam int SETTLE_CYCLES     = 40;
  localparam int SEGMENTS          = 12;
  localparam int TICKS_PER_SEGMENT = 59;

  logic clk = 1'b0;
  logic rst_n;
  int   in_idle_pct;
  int   out_idle_pct;
  int   mismatches;
  int   outstanding;
  int   quiet_cycles = 0;

  always #10 clk = ~clk;

  svpwm_in_if  in_ch ();
  svpwm_out_if out_ch ();
  svpwm_cfg_if cfg_ch ();

  svpwm_compare_generator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  svpwm_compare_check check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Output back-pressure: drop ready at random, at the rate of the current phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Watchdog: end the run if no channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one input word after a random gap; leave valid high on return so
  // that a following word can go straight out on the next edge.
  task automatic send_word(input logic reload);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.reload <= reload;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Write all four registers back to back, then drop the write strobe
  task automatic set_config(input logic [CFG_DATA_W-1:0] half_period,
                            input logic [CFG_DATA_W-1:0] mod_index,
                            input logic [CFG_DATA_W-1:0] phase_step,
                            input logic [CFG_DATA_W-1:0] count_limit);
    write_reg(REG_HALF_PERIOD, half_period);
    write_reg(REG_MOD_INDEX, mod_index);
    write_reg(REG_PHASE_STEP, phase_step);
    write_reg(REG_COUNT_LIMIT, count_limit);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold input idle until every predicted word has come out, then wait out the
  // settling margin.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] hp, mi, step, limit;
    logic                  reload;
    int                    ticks;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.reload     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_HALF_PERIOD;
    cfg_ch.wdata     = '0;
    in_idle_pct      = 27;
    out_idle_pct     = 66;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, with words that carry no reload mixed in
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b1);
    settle();

    // Zero half period, full modulation, phase step 1199, restart every tick
    set_config(16'd0, 16'hFFFF, 16'd1199, 16'd0);
    repeat (3) send_word(1'b1);
    settle();

    // Widest period and index; a step of one sector lands on every boundary
    set_config(16'hFFFF, 16'hFFFF, 16'd200, 16'hFFFF);
    repeat (7) send_word(1'b1);
    settle();

    // Smallest nonzero period, zero index, largest step the field holds, short count
    set_config(16'd1, 16'd0, 16'd2047, 16'd2);
    repeat (4) send_word(1'b1);
    settle();

    // Random part: receiver-idle phase, sender-idle phase, then full rate
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < SEGMENTS / 3) begin
        in_idle_pct  = 27;
        out_idle_pct = 66;
      end else if (seg < 2 * SEGMENTS / 3) begin
        in_idle_pct  = 66;
        out_idle_pct = 27;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end

      case ($urandom_range(3))
        0:       hp = 16'($urandom_range(1, 64));
        1:       hp = 16'hFFFF;
        2:       hp = 16'($urandom_range(1000, 20000));
        default: hp = 16'($urandom_range(0, 65535));
      endcase
      mi    = ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      step  = 16'($urandom_range(0, 2047));
      // Mostly short counts so the restart comes round often
      limit = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 100));
      set_config(hp, mi, step, limit);

      ticks = 0;
      while (ticks < TICKS_PER_SEGMENT) begin
        reload = ($urandom_range(99) < 85);
        send_word(reload);
        if (reload) ticks++;
      end
      settle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: svpwm_compare_generator.f
rtl/core/svpwm_pkg.sv
rtl/core/svpwm_in_if.sv
rtl/core/svpwm_out_if.sv
rtl/core/svpwm_cfg_if.sv
rtl/core/svpwm_ctrl.sv
rtl/core/svpwm_dp.sv
rtl/core/svpwm_compare_generator.sv
sim/svpwm_compare_check.sv
sim/testbench.sv
